>>> design/clsp_pkg.sv
// Shared types, codes and constants of the closed-loop stepper positioner.
package clsp_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int POS_W      = 32;
  localparam int CFG_W      = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int INTERVAL_W = 26;
  localparam int PROD_W     = 32;
  localparam int DIV_CNT_W  = 5;
  localparam int RAW_W      = SAMPLE_W + 1;
  localparam int MCAND_W    = CFG_W + 1;
  localparam int SPROD_W    = RAW_W + MCAND_W;
  localparam int WIDE_W     = 64;

  localparam logic [INTERVAL_W-1:0] STEP_DIVIDEND  = 26'd60000000;
  localparam logic [INTERVAL_W-1:0] RESET_INTERVAL = 26'd10000;
  localparam logic [MCAND_W-1:0]    DEGREES_FULL   = 25'd360;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_UNIT_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CUSTOM_SCALE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEPS_PER_REV = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_RPM     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TORQUE   = 3'd4;

  // Unit modes
  localparam logic [1:0] MODE_ANGLE  = 2'd0;
  localparam logic [1:0] MODE_MOTOR  = 2'd1;
  localparam logic [1:0] MODE_SCALED = 2'd2;

  // Operations
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  localparam logic [3:0] COILS_OFF = 4'd0;

  typedef struct packed {
    logic                    operation;
    logic signed [POS_W-1:0] target_position;
    logic [SAMPLE_W-1:0]     encoder_sample;
    logic                    sample_valid;
  } in_item_t;

  typedef struct packed {
    logic [3:0]              coil_drive;
    logic                    busy_res;
    logic                    move_done;
    logic signed [POS_W-1:0] step_count;
    logic signed [POS_W-1:0] measured_position;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic scale;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
  } dp_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_SCALE,
    ST_EVAL
  } ctrl_state_t;

  function automatic logic [3:0] fwd_pattern(input logic [1:0] ph);
    logic [3:0] p;
    unique case (ph)
      2'd0: p = 4'd9;
      2'd1: p = 4'd10;
      2'd2: p = 4'd6;
      default: p = 4'd5;
    endcase
    return p;
  endfunction

  function automatic logic [3:0] bwd_pattern(input logic [1:0] ph);
    logic [3:0] p;
    unique case (ph)
      2'd0: p = 4'd5;
      2'd1: p = 4'd6;
      2'd2: p = 4'd10;
      default: p = 4'd9;
    endcase
    return p;
  endfunction

endpackage

>>> design/clsp_div.sv
// Step interval unit: rpm times steps, then a one-bit-a-cycle restoring divide.
module clsp_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [15:0]                         speed_rpm,
  input  logic [15:0]                         steps_per_rev,
  output logic                                busy,
  output logic [clsp_pkg::INTERVAL_W-1:0]     step_interval
);

  logic                                run_r;
  logic [clsp_pkg::DIV_CNT_W-1:0]      cnt_r;
  logic [clsp_pkg::INTERVAL_W-1:0]     interval_r;
  logic [clsp_pkg::PROD_W-1:0]         prod_r;
  logic [clsp_pkg::PROD_W-1:0]         rem_r;
  logic [clsp_pkg::INTERVAL_W-1:0]     quo_r;

  logic [clsp_pkg::PROD_W-1:0]         divisor;
  logic [clsp_pkg::PROD_W:0]           trial;
  logic [clsp_pkg::PROD_W-1:0]         rem_nxt;
  logic [clsp_pkg::INTERVAL_W-1:0]     quo_nxt;
  logic                                last_bit;

  always_comb begin
    // a zero product counts as one
    divisor = (prod_r == '0) ? clsp_pkg::PROD_W'(1) : prod_r;
    trial   = {rem_r, quo_r[clsp_pkg::INTERVAL_W-1]};
    if (trial >= {1'b0, divisor}) begin
      rem_nxt = clsp_pkg::PROD_W'(trial - {1'b0, divisor});
      quo_nxt = {quo_r[clsp_pkg::INTERVAL_W-2:0], 1'b1};
    end else begin
      rem_nxt = trial[clsp_pkg::PROD_W-1:0];
      quo_nxt = {quo_r[clsp_pkg::INTERVAL_W-2:0], 1'b0};
    end
    last_bit = (cnt_r == clsp_pkg::DIV_CNT_W'(clsp_pkg::INTERVAL_W - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r      <= 1'b0;
      cnt_r      <= '0;
      interval_r <= clsp_pkg::RESET_INTERVAL;
    end else if (start) begin
      run_r <= 1'b1;
      cnt_r <= '0;
    end else if (run_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (last_bit) begin
        run_r      <= 1'b0;
        // clamp the interval to at least one tick
        interval_r <= (quo_nxt == '0) ? clsp_pkg::INTERVAL_W'(1) : quo_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod_r <= clsp_pkg::PROD_W'(speed_rpm * steps_per_rev);
      rem_r  <= '0;
      quo_r  <= clsp_pkg::STEP_DIVIDEND;
    end else if (run_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign busy          = start | run_r;
  assign step_interval = interval_r;

  a_interval_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    interval_r != '0)
    else $error("step interval is zero");

endmodule

>>> design/clsp_datapath.sv
// Datapath: configuration, sample scaling, deadband check and motion state.
module clsp_datapath #(
  parameter int ENCODER_BITS       = 12,
  parameter int POSITION_FRAC_BITS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  clsp_pkg::dp_cmd_t                    cmd,
  output clsp_pkg::dp_stat_t                   stat,
  input  clsp_pkg::in_item_t                   in_data,
  output clsp_pkg::out_item_t                  out_data,
  input  logic                                 cfg_we,
  input  logic [clsp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [clsp_pkg::CFG_W-1:0]           cfg_wdata
);

  localparam logic [clsp_pkg::SAMPLE_W-1:0] SAMPLE_MASK =
    (ENCODER_BITS >= clsp_pkg::SAMPLE_W) ? {clsp_pkg::SAMPLE_W{1'b1}} :
    clsp_pkg::SAMPLE_W'((1 << ENCODER_BITS) - 1);
  localparam logic signed [clsp_pkg::POS_W:0] DEADBAND =
    (clsp_pkg::POS_W + 1)'(1 << POSITION_FRAC_BITS);
  localparam logic signed [clsp_pkg::WIDE_W-1:0] POS_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [clsp_pkg::WIDE_W-1:0] POS_MIN = -64'sh0000_0000_8000_0000;

  // configuration registers
  logic [1:0]                  unit_mode_r;
  logic [clsp_pkg::CFG_W-1:0]  custom_scale_r;
  logic [15:0]                 steps_per_rev_r;
  logic [15:0]                 speed_rpm_r;
  logic                        hold_torque_r;
  logic                        div_start_r;

  // motion state
  logic [1:0]                            phase_r, phase_nxt;
  logic [clsp_pkg::POS_W-1:0]            net_steps_r, net_steps_nxt;
  logic [clsp_pkg::INTERVAL_W-1:0]       wait_ticks_r, wait_ticks_nxt;
  logic signed [clsp_pkg::POS_W-1:0]     target_r, target_nxt;
  logic signed [clsp_pkg::POS_W-1:0]     last_pos_r, last_pos_nxt;
  logic                                  moving_r, moving_nxt;
  logic [3:0]                            coil_r, coil_nxt;
  logic                                  done;

  // per-item work registers
  clsp_pkg::in_item_t                    item_r;
  logic signed [clsp_pkg::SPROD_W-1:0]   sprod_r;
  logic signed [clsp_pkg::POS_W-1:0]     pos_r;
  clsp_pkg::out_item_t                   out_r;

  logic                                  div_busy;
  logic [clsp_pkg::INTERVAL_W-1:0]       step_interval;

  logic signed [clsp_pkg::RAW_W-1:0]     raw;
  logic signed [clsp_pkg::MCAND_W-1:0]   mcand;
  logic signed [clsp_pkg::WIDE_W-1:0]    wide;
  logic signed [clsp_pkg::WIDE_W-1:0]    scaled;
  logic signed [clsp_pkg::POS_W-1:0]     tgt;
  logic signed [clsp_pkg::POS_W:0]       diff;
  logic signed [clsp_pkg::POS_W:0]       abs_diff;
  logic                                  in_band;
  logic                                  below;

  clsp_div u_div (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (div_start_r),
    .speed_rpm     (speed_rpm_r),
    .steps_per_rev (steps_per_rev_r),
    .busy          (div_busy),
    .step_interval (step_interval)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_mode_r     <= clsp_pkg::MODE_ANGLE;
      custom_scale_r  <= 24'd65536;
      steps_per_rev_r <= 16'd200;
      speed_rpm_r     <= 16'd30;
      hold_torque_r   <= 1'b1;
      div_start_r     <= 1'b0;
    end else begin
      div_start_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          clsp_pkg::CFG_UNIT_MODE:    unit_mode_r    <= cfg_wdata[1:0];
          clsp_pkg::CFG_CUSTOM_SCALE: custom_scale_r <= cfg_wdata;
          clsp_pkg::CFG_STEPS_PER_REV: begin
            steps_per_rev_r <= cfg_wdata[15:0];
            div_start_r     <= 1'b1;
          end
          clsp_pkg::CFG_SPEED_RPM: begin
            speed_rpm_r <= cfg_wdata[15:0];
            div_start_r <= 1'b1;
          end
          clsp_pkg::CFG_HOLD_TORQUE:  hold_torque_r  <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  // multiply: raw sample (or -1 without a valid sample) times the unit factor
  always_comb begin
    raw = item_r.sample_valid ?
          $signed({1'b0, item_r.encoder_sample & SAMPLE_MASK}) :
          -clsp_pkg::RAW_W'(1);
    unique case (unit_mode_r)
      clsp_pkg::MODE_ANGLE:  mcand = clsp_pkg::DEGREES_FULL;
      clsp_pkg::MODE_SCALED: mcand = $signed({1'b0, custom_scale_r});
      default:               mcand = $signed({9'd0, steps_per_rev_r});
    endcase
  end

  // scale: floor shift and saturate to Q24.8
  always_comb begin
    wide = clsp_pkg::WIDE_W'(sprod_r) <<< POSITION_FRAC_BITS;
    if (unit_mode_r == clsp_pkg::MODE_SCALED) begin
      scaled = wide >>> 16;
    end else begin
      scaled = wide >>> ENCODER_BITS;
    end
  end

  // evaluate and build the next motion state
  always_comb begin
    tgt      = (item_r.operation == clsp_pkg::OP_START) ? item_r.target_position : target_r;
    diff     = (clsp_pkg::POS_W + 1)'(pos_r) - (clsp_pkg::POS_W + 1)'(tgt);
    abs_diff = (diff < 0) ? -diff : diff;
    in_band  = (abs_diff <= DEADBAND);
    below    = (pos_r < tgt);

    phase_nxt      = phase_r;
    net_steps_nxt  = net_steps_r;
    wait_ticks_nxt = wait_ticks_r;
    target_nxt     = target_r;
    last_pos_nxt   = last_pos_r;
    moving_nxt     = moving_r;
    coil_nxt       = coil_r;
    done           = 1'b0;

    if (item_r.operation == clsp_pkg::OP_START) begin
      target_nxt     = item_r.target_position;
      last_pos_nxt   = pos_r;
      wait_ticks_nxt = '0;
      if (in_band) begin
        moving_nxt = 1'b0;
        done       = 1'b1;
        if (!hold_torque_r) coil_nxt = clsp_pkg::COILS_OFF;
      end else begin
        moving_nxt = 1'b1;
      end
    end else if (moving_r) begin
      if (wait_ticks_r != '0) begin
        wait_ticks_nxt = wait_ticks_r - 1'b1;
      end else begin
        last_pos_nxt = pos_r;
        if (in_band) begin
          moving_nxt = 1'b0;
          done       = 1'b1;
          if (!hold_torque_r) coil_nxt = clsp_pkg::COILS_OFF;
        end else begin
          if (below) begin
            coil_nxt      = clsp_pkg::fwd_pattern(phase_r);
            phase_nxt     = phase_r + 2'd1;
            net_steps_nxt = net_steps_r + 1'b1;
          end else begin
            coil_nxt      = clsp_pkg::bwd_pattern(phase_r);
            phase_nxt     = phase_r - 2'd1;
            net_steps_nxt = net_steps_r - 1'b1;
          end
          wait_ticks_nxt = step_interval - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= '0;
      net_steps_r  <= '0;
      wait_ticks_r <= '0;
      target_r     <= '0;
      last_pos_r   <= '0;
      moving_r     <= 1'b0;
      coil_r       <= clsp_pkg::COILS_OFF;
    end else if (cmd.commit) begin
      phase_r      <= phase_nxt;
      net_steps_r  <= net_steps_nxt;
      wait_ticks_r <= wait_ticks_nxt;
      target_r     <= target_nxt;
      last_pos_r   <= last_pos_nxt;
      moving_r     <= moving_nxt;
      coil_r       <= coil_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_data;
    if (cmd.mul) sprod_r <= raw * mcand;
    if (cmd.scale) begin
      if (scaled > POS_MAX) begin
        pos_r <= POS_MAX[clsp_pkg::POS_W-1:0];
      end else if (scaled < POS_MIN) begin
        pos_r <= POS_MIN[clsp_pkg::POS_W-1:0];
      end else begin
        pos_r <= scaled[clsp_pkg::POS_W-1:0];
      end
    end
    if (cmd.commit) begin
      out_r.coil_drive        <= coil_nxt;
      out_r.busy_res          <= moving_nxt;
      out_r.move_done         <= done;
      out_r.step_count        <= net_steps_nxt;
      out_r.measured_position <= last_pos_nxt;
    end
  end

  assign out_data      = out_r;
  assign stat.div_busy = div_busy | div_start_r;

  a_step_moves_phase: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && net_steps_r != $past(net_steps_r)) |-> phase_r != $past(phase_r))
    else $error("step count changed without a phase change");

endmodule

>>> design/clsp_ctrl.sv
// Controller: sequences accept, multiply, scale and commit of one request.
module clsp_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  clsp_pkg::dp_stat_t   stat,
  output clsp_pkg::dp_cmd_t    cmd
);

  clsp_pkg::ctrl_state_t state_r, state_nxt;
  logic                  out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= clsp_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state_r)
      clsp_pkg::ST_IDLE: begin
        // hold off requests while the interval divide runs
        in_stall = stat.div_busy;
        if (in_valid && !stat.div_busy) begin
          cmd.load  = 1'b1;
          state_nxt = clsp_pkg::ST_MUL;
        end
      end
      clsp_pkg::ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = clsp_pkg::ST_SCALE;
      end
      clsp_pkg::ST_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = clsp_pkg::ST_EVAL;
      end
      clsp_pkg::ST_EVAL: begin
        // commit once the output register is free
        if (!out_valid_r || !out_stall) begin
          cmd.commit = 1'b1;
          state_nxt  = clsp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = clsp_pkg::ST_IDLE;
    endcase

    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

  a_rise_after_eval: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == clsp_pkg::ST_EVAL))
    else $error("result appeared without a commit");

  a_accept_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> (state_r == clsp_pkg::ST_IDLE && !stat.div_busy))
    else $error("request accepted outside idle");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !(out_valid_r && out_stall))
    else $error("commit over a held result");

endmodule

>>> design/closed_loop_stepper_positioner.sv
// Top level of the closed-loop full-step stepper positioner.
//
//  channel  direction  handshake            payload
//  in_      input      in_valid / in_stall  clsp_pkg::in_item_t
//  out_     output     out_valid/out_stall  clsp_pkg::out_item_t
//  cfg_     input      cfg_we               cfg_index, cfg_wdata
//
// Each request steps through accept, multiply, scale, then evaluate and commit.
// A new request is taken in the cycle after commit while the result waits, unless an interval divide is running.
// Writing steps_per_rev or speed_rpm starts an interval divide
// (a product step, then one quotient bit a cycle); input stalls meanwhile.
// Reset is synchronous, active low; no clearing pass follows it.
// A stalled result holds the commit of the following request in evaluate.
module closed_loop_stepper_positioner #(
  parameter int ENCODER_BITS       = 12,
  parameter int POSITION_FRAC_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  clsp_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output clsp_pkg::out_item_t               out_data,
  input  logic                              cfg_we,
  input  logic [clsp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [clsp_pkg::CFG_W-1:0]        cfg_wdata
);

  clsp_pkg::dp_cmd_t  cmd;
  clsp_pkg::dp_stat_t stat;

  clsp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  clsp_datapath #(
    .ENCODER_BITS       (ENCODER_BITS),
    .POSITION_FRAC_BITS (POSITION_FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

endmodule
